[rtl/bmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, address map constants and decode helpers of the banked memory controller.
package bmc_pkg;

  // Item codes on the op field; codes above OP_LOAD_BOOT do nothing.
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_TICK      = 3'd2;
  localparam logic [2:0] OP_LOAD_ROM  = 3'd3;
  localparam logic [2:0] OP_LOAD_BOOT = 3'd4;

  localparam int unsigned ROM_BANKS_DEF = 128;
  localparam int unsigned BANK_BYTES    = 16384;
  localparam int unsigned OFS_W         = $clog2(BANK_BYTES);
  localparam int unsigned ROM_FULL_AW   = 21;
  localparam int unsigned BANK_W        = ROM_FULL_AW - OFS_W;
  localparam int unsigned WMEM_AW       = 15;
  localparam int unsigned WMEM_DEPTH    = 1 << WMEM_AW;

  localparam logic [15:0] BOOT_TOP     = 16'h0100;
  localparam logic [15:0] ECHO_LO      = 16'hE000;
  localparam logic [15:0] ECHO_HI      = 16'hFDFF;
  localparam logic [15:0] ECHO_OFS     = 16'h2000;
  localparam logic [15:0] REG_BANK_LO  = 16'h2000;
  localparam logic [15:0] BANKX_LO     = 16'h4000;
  localparam logic [15:0] REG_RTC_LO   = 16'h4000;
  localparam logic [15:0] REG_LATCH_LO = 16'h6000;
  localparam logic [15:0] WMEM_LO      = 16'h8000;
  localparam logic [15:0] RTC_LO       = 16'hA000;
  localparam logic [15:0] RTC_HI       = 16'hBFFF;
  localparam logic [15:0] DMA_REG      = 16'hFF46;
  localparam logic [15:0] BOOT_OFF_REG = 16'hFF50;
  localparam logic [15:0] DMA_DEST     = 16'hFE00;
  localparam logic [7:0]  DMA_LEN      = 8'hA0;
  localparam logic [WMEM_AW-1:0] DMA_DEST_OFS = WMEM_AW'(DMA_DEST - WMEM_LO);

  localparam logic [5:0] SECS_MAX      = 6'd59;   // 60 counts per roll-over
  localparam logic [7:0] RTC_SEL_MIN   = 8'd8;
  localparam logic [7:0] RTC_SEL_SEC   = 8'd8;
  localparam logic [7:0] RTC_SEL_MINS  = 8'd9;
  localparam logic [7:0] WMEM_FILL     = 8'hFF;

  typedef enum logic [1:0] {
    SRC_BOOT,
    SRC_ROM,
    SRC_WMEM,
    SRC_CLOCK
  } src_t;

  typedef struct packed {
    src_t        src;
    logic        banked;
    logic [15:0] addr;
  } dec_t;

  typedef struct packed {
    logic                   boot_en;
    logic [7:0]             boot_addr;
    logic                   rom_en;
    logic [ROM_FULL_AW-1:0] rom_addr;
    logic                   wmem_en;
    logic [WMEM_AW-1:0]     wmem_addr;
  } mem_rd_t;

  typedef struct packed {
    logic                   boot_we;
    logic [7:0]             boot_addr;
    logic                   rom_we;
    logic [ROM_FULL_AW-1:0] rom_addr;
    logic [7:0]             load_data;
    logic                   wmem_we;
    logic [WMEM_AW-1:0]     wmem_addr;
    logic [7:0]             wmem_data;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0] boot_q;
    logic [7:0] rom_q;
    logic [7:0] wmem_q;
  } mem_q_t;

  typedef struct packed {
    logic       tick;
    logic       wr_bank;
    logic       wr_rtc;
    logic       wr_latch;
    logic       boot_off;
    logic [7:0] data;
  } rtc_cmd_t;

  typedef struct packed {
    logic [7:0] rom_bank;
    logic       boot_active;
    logic       rtc_on;
    logic [5:0] rtc_value;
  } rtc_stat_t;

  // Fold the echo window down onto work memory.
  function automatic logic [15:0] echo_map(input logic [15:0] addr);
    logic [15:0] a;
    a = addr;
    if (a inside {[ECHO_LO:ECHO_HI]}) begin
      a = a - ECHO_OFS;
    end
    return a;
  endfunction

  // Pick the source of a bus read.
  function automatic dec_t bus_decode(input logic [15:0] addr, input logic boot_on,
                                      input logic rtc_on);
    dec_t        d;
    logic [15:0] a;
    a = echo_map(addr);
    d.addr = a;
    d.banked = 1'b0;
    if (boot_on && addr < BOOT_TOP) begin
      d.src = SRC_BOOT;
    end else if (a < BANKX_LO) begin
      d.src = SRC_ROM;
    end else if (a < WMEM_LO) begin
      d.src = SRC_ROM;
      d.banked = 1'b1;
    end else if (rtc_on && (a inside {[RTC_LO:RTC_HI]})) begin
      d.src = SRC_CLOCK;
    end else begin
      d.src = SRC_WMEM;
    end
    return d;
  endfunction

endpackage

[rtl/bmc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for bus items and read results.
interface bmc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] bus_address;
  logic [20:0] load_address;
  logic [7:0]  write_data;

  modport source (output valid, op, bus_address, load_address, write_data, input ready);
  modport sink (input valid, op, bus_address, load_address, write_data, output ready);
endinterface

interface bmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

[rtl/bmc_rtc.sv]
`timescale 1ns / 1ps
// Bank select, clock select, latch and the seconds and minutes clock registers.
module bmc_rtc (
  input  logic               clk,
  input  logic               rst_n,
  input  bmc_pkg::rtc_cmd_t  cmd,
  output bmc_pkg::rtc_stat_t stat
);
  import bmc_pkg::*;

  logic [7:0] rom_bank_r;
  logic [7:0] rtc_sel_r;
  logic       latch_on_r;
  logic [7:0] prev_latch_r;
  logic       boot_active_r;
  logic [5:0] live_sec_r;
  logic [5:0] live_min_r;
  logic [5:0] snap_sec_r;
  logic [5:0] snap_min_r;
  logic [5:0] sec_sel;
  logic [5:0] min_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r    <= '0;
      rtc_sel_r     <= '0;
      latch_on_r    <= 1'b0;
      prev_latch_r  <= '0;
      boot_active_r <= 1'b1;
      live_sec_r    <= '0;
      live_min_r    <= '0;
      snap_sec_r    <= '0;
      snap_min_r    <= '0;
    end else begin
      if (cmd.wr_bank) begin
        rom_bank_r <= cmd.data;
      end
      if (cmd.wr_rtc) begin
        rtc_sel_r <= cmd.data;
      end
      if (cmd.boot_off) begin
        boot_active_r <= 1'b0;
      end
      if (cmd.wr_latch) begin
        // toggle on a 0 then 1 sequence; capture when switching on
        if (prev_latch_r == 8'd0 && cmd.data == 8'd1) begin
          latch_on_r <= ~latch_on_r;
          if (!latch_on_r) begin
            snap_sec_r <= live_sec_r;
            snap_min_r <= live_min_r;
          end
        end
        prev_latch_r <= cmd.data;
      end
      if (cmd.tick) begin
        if (live_sec_r == SECS_MAX) begin
          live_sec_r <= '0;
          live_min_r <= (live_min_r == SECS_MAX) ? 6'd0 : live_min_r + 6'd1;
        end else begin
          live_sec_r <= live_sec_r + 6'd1;
        end
      end
    end
  end

  assign sec_sel = latch_on_r ? snap_sec_r : live_sec_r;
  assign min_sel = latch_on_r ? snap_min_r : live_min_r;

  always_comb begin
    stat.rom_bank    = rom_bank_r;
    stat.boot_active = boot_active_r;
    stat.rtc_on      = (rtc_sel_r >= RTC_SEL_MIN);
    case (rtc_sel_r)
      RTC_SEL_SEC:  stat.rtc_value = sec_sel;
      RTC_SEL_MINS: stat.rtc_value = min_sel;
      default:      stat.rtc_value = 6'd0;
    endcase
  end

endmodule

[rtl/bmc_store.sv]
`timescale 1ns / 1ps
// Cartridge ROM, boot ROM and work memory with registered reads and the work memory fill pass.
module bmc_store #(
  parameter int unsigned ROM_BANKS = bmc_pkg::ROM_BANKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bmc_pkg::mem_rd_t rd,
  input  bmc_pkg::mem_wr_t wr,
  output bmc_pkg::mem_q_t  q,
  output logic             clr_busy
);
  import bmc_pkg::*;

  // Only the first 2^BANK_W banks are reachable through the bank window.
  localparam int unsigned ROM_READ_BANKS = (ROM_BANKS > (1 << BANK_W)) ? (1 << BANK_W)
                                                                       : ROM_BANKS;
  localparam int unsigned ROM_DEPTH = ROM_READ_BANKS * BANK_BYTES;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  localparam logic [ROM_FULL_AW:0] ROM_LIMIT = (ROM_FULL_AW + 1)'(ROM_DEPTH);

  logic [7:0] rom_mem  [ROM_DEPTH];
  logic [7:0] boot_mem [256];
  logic [7:0] wmem     [WMEM_DEPTH];

  logic               clr_busy_r;
  logic [WMEM_AW-1:0] clr_cnt_r;
  logic               wm_we;
  logic [WMEM_AW-1:0] wm_addr;
  logic [7:0]         wm_data;
  logic               rom_we;
  logic [7:0]         boot_q_r;
  logic [7:0]         rom_q_r;
  logic [7:0]         wmem_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == WMEM_AW'(WMEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign clr_busy = clr_busy_r;
  assign wm_we    = clr_busy_r || wr.wmem_we;
  assign wm_addr  = clr_busy_r ? clr_cnt_r : wr.wmem_addr;
  assign wm_data  = clr_busy_r ? WMEM_FILL : wr.wmem_data;
  assign rom_we   = wr.rom_we && ({1'b0, wr.rom_addr} < ROM_LIMIT);
  assign q        = '{boot_q: boot_q_r, rom_q: rom_q_r, wmem_q: wmem_q_r};

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_addr] <= wm_data;
    end
    if (rd.wmem_en) begin
      wmem_q_r <= wmem[rd.wmem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[wr.rom_addr[ROM_AW-1:0]] <= wr.load_data;
    end
    if (rd.rom_en) begin
      rom_q_r <= rom_mem[rd.rom_addr[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.boot_we) begin
      boot_mem[wr.boot_addr] <= wr.load_data;
    end
    if (rd.boot_en) begin
      boot_q_r <= boot_mem[rd.boot_addr];
    end
  end

endmodule

[rtl/banked_memory_controller_rtc.sv]
`timescale 1ns / 1ps
// Top level of the banked memory controller with a seconds and minutes clock and sprite copy.
//
// Usage:
//   in_ch carries one item per word: a bus read, a bus write, a one-second tick,
//   or a byte load into cartridge ROM or boot ROM. out_ch carries one read_data
//   word for every bus read, in order; no other item produces a word.
//   Reads, writes, ticks and loads are taken one per cycle while in_ch is ready. A
//   read's word passes through the read stage and the output register to out_ch.
//   A write to the copy register (0xFF46) holds in_ch ready low while the 160-byte
//   copy runs: a wait for a pending read to reach the output register, a read of
//   each of the 160 source bytes on the memory ports and the write of the last
//   byte, before the next word is taken.
//   After reset the work memory is filled with 0xFF, one byte a cycle, across all
//   32768 bytes; in_ch is not ready during that pass. ROM contents are kept.
//   When out_ch stalls, one finished word waits in the output register and one
//   more read may be in flight; further words on in_ch then wait until the
//   output register is taken.
module banked_memory_controller_rtc #(
  parameter int unsigned ROM_BANKS = bmc_pkg::ROM_BANKS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bmc_in_if.sink   in_ch,
  bmc_out_if.source out_ch
);
  import bmc_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DMA_WAIT,
    ST_DMA_RUN
  } state_t;

  state_t     state_r;
  logic [7:0] dma_src_r;
  logic [7:0] dma_cnt_r;

  // read stage: a bus read whose memory data arrives this cycle
  logic       p1_valid_r;
  src_t       p1_src_r;
  logic [5:0] p1_clk_r;

  // copy stage: a copy source byte arriving, to be written at the copy target
  logic       d1_valid_r;
  logic [7:0] d1_idx_r;
  src_t       d1_src_r;
  logic [5:0] d1_clk_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;

  rtc_cmd_t  cmd;
  rtc_stat_t stat;
  mem_rd_t   mrd;
  mem_wr_t   mwr;
  mem_q_t    mq;
  logic      clr_busy;

  logic        in_fire;
  logic        rd_accept;
  logic        wr_item;
  logic        dma_start;
  logic        dma_issue;
  logic        p1_move;
  logic        p1_block;
  logic [15:0] iss_addr;
  dec_t        dec;
  logic [15:0] wa;
  logic [7:0]  bank_lut [256];
  logic [7:0]  bank_sel;

  // Bank table: select 0 reads bank 1, any other select wraps at the ROM size.
  for (genvar g = 0; g < 256; g++) begin : g_bank
    localparam int unsigned BM = (g == 0) ? 1 : (g % ROM_BANKS);
    assign bank_lut[g] = 8'(BM);
  end

  function automatic logic [7:0] pick(input src_t src, input mem_q_t d, input logic [5:0] c);
    case (src)
      SRC_BOOT:  return d.boot_q;
      SRC_ROM:   return d.rom_q;
      SRC_CLOCK: return {2'b00, c};
      default:   return d.wmem_q;
    endcase
  endfunction

  // Accept only in the run state, outside the fill pass, with the copy drained,
  // and never onto a read stage that cannot advance into the output register.
  assign p1_block    = p1_valid_r && out_valid_r && !out_ch.ready;
  assign p1_move     = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_RUN) && !d1_valid_r && !clr_busy && !p1_block;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rd_accept   = in_fire && (in_ch.op == OP_READ);
  assign wr_item     = in_fire && (in_ch.op == OP_WRITE);
  assign dma_issue   = (state_r == ST_DMA_RUN);

  // One read decode, shared by bus reads and copy source reads.
  assign iss_addr = dma_issue ? {dma_src_r, dma_cnt_r} : in_ch.bus_address;
  assign dec      = bus_decode(iss_addr, stat.boot_active, stat.rtc_on);
  assign bank_sel = dec.banked ? bank_lut[stat.rom_bank] : 8'd0;

  always_comb begin
    mrd.boot_en   = (rd_accept || dma_issue) && (dec.src == SRC_BOOT);
    mrd.boot_addr = dec.addr[7:0];
    mrd.rom_en    = (rd_accept || dma_issue) && (dec.src == SRC_ROM);
    mrd.rom_addr  = {bank_sel[BANK_W-1:0], dec.addr[OFS_W-1:0]};
    mrd.wmem_en   = (rd_accept || dma_issue) && (dec.src == SRC_WMEM);
    mrd.wmem_addr = dec.addr[WMEM_AW-1:0];
  end

  // Write side: control registers below work memory, then the two special
  // registers, then plain stores.
  assign wa        = echo_map(in_ch.bus_address);
  assign dma_start = wr_item && (wa == DMA_REG);

  always_comb begin
    cmd.tick     = in_fire && (in_ch.op == OP_TICK);
    cmd.wr_bank  = wr_item && (wa inside {[REG_BANK_LO:REG_RTC_LO - 16'd1]});
    cmd.wr_rtc   = wr_item && (wa inside {[REG_RTC_LO:REG_LATCH_LO - 16'd1]});
    cmd.wr_latch = wr_item && (wa inside {[REG_LATCH_LO:WMEM_LO - 16'd1]});
    cmd.boot_off = wr_item && (wa == BOOT_OFF_REG);
    cmd.data     = in_ch.write_data;
  end

  always_comb begin
    mwr.rom_we    = in_fire && (in_ch.op == OP_LOAD_ROM);
    mwr.rom_addr  = in_ch.load_address;
    mwr.boot_we   = in_fire && (in_ch.op == OP_LOAD_BOOT) &&
                    (in_ch.load_address[ROM_FULL_AW-1:8] == '0);
    mwr.boot_addr = in_ch.load_address[7:0];
    mwr.load_data = in_ch.write_data;
    if (d1_valid_r) begin
      mwr.wmem_we   = 1'b1;
      mwr.wmem_addr = DMA_DEST_OFS + WMEM_AW'(d1_idx_r);
      mwr.wmem_data = pick(d1_src_r, mq, d1_clk_r);
    end else begin
      mwr.wmem_we   = wr_item && (wa >= WMEM_LO) && (wa != DMA_REG);
      mwr.wmem_addr = wa[WMEM_AW-1:0];
      mwr.wmem_data = in_ch.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      p1_valid_r  <= 1'b0;
      d1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dma_cnt_r   <= '0;
    end else begin
      // output register: advance the read stage, drop a taken word
      if (p1_move) begin
        out_valid_r <= 1'b1;
        out_data_r  <= pick(p1_src_r, mq, p1_clk_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (rd_accept) begin
        p1_valid_r <= 1'b1;
        p1_src_r   <= dec.src;
        p1_clk_r   <= stat.rtc_value;
      end else if (p1_move) begin
        p1_valid_r <= 1'b0;
      end

      d1_valid_r <= dma_issue;
      d1_idx_r   <= dma_cnt_r;
      d1_src_r   <= dec.src;
      d1_clk_r   <= stat.rtc_value;

      case (state_r)
        ST_RUN: begin
          if (dma_start) begin
            dma_src_r <= in_ch.write_data;
            dma_cnt_r <= '0;
            state_r   <= ST_DMA_WAIT;
          end
        end
        ST_DMA_WAIT: begin
          // hold until the pending read no longer needs the memory data
          if (!p1_valid_r) begin
            state_r <= ST_DMA_RUN;
          end
        end
        ST_DMA_RUN: begin
          dma_cnt_r <= dma_cnt_r + 8'd1;
          if (dma_cnt_r == DMA_LEN - 8'd1) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

  bmc_rtc u_rtc (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  bmc_store #(
    .ROM_BANKS(ROM_BANKS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (mrd),
    .wr      (mwr),
    .q       (mq),
    .clr_busy(clr_busy)
  );

`ifndef ASSERT_OFF
  a_copy_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    d1_valid_r |-> $past(state_r == ST_DMA_RUN))
    else $error("copy write without a copy read");

  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(p1_valid_r && d1_valid_r))
    else $error("bus read and copy share the memory data");

  a_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_accept |=> p1_valid_r)
    else $error("accepted read lost");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DMA_RUN) |-> (dma_cnt_r < DMA_LEN))
    else $error("copy counter past its length");
`endif

endmodule
